[hw/rtl/ameb_pkg.sv]
`timescale 1ns / 1ps

package ameb_pkg;

  localparam int CH_BITS       = 3;
  localparam int ALPHA_BITS    = 15;
  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 15'd32604;

  // Register indexes (byte address divided by four).
  localparam logic REG_DC_ALPHA = 1'b0;

  typedef enum logic [2:0] {
    F_IDLE,
    F_SQR,
    F_SUM,
    F_ROOT,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_MUL,
    B_SUM
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

[hw/rtl/ameb_in_if.sv]
`timescale 1ns / 1ps

interface ameb_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic [ameb_pkg::CH_BITS-1:0]  channel;
  logic signed [SAMPLE_BITS-1:0] sample_i;
  logic signed [SAMPLE_BITS-1:0] sample_q;

  modport source (output valid, channel, sample_i, sample_q, input ready);
  modport sink   (input valid, channel, sample_i, sample_q, output ready);
endinterface

[hw/rtl/ameb_out_if.sv]
`timescale 1ns / 1ps

interface ameb_out_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                            valid;
  logic                            ready;
  logic [ameb_pkg::CH_BITS-1:0]    out_channel;
  logic signed [SAMPLE_BITS+2:0]   demod_value;

  modport source (output valid, out_channel, demod_value, input ready);
  modport sink   (input valid, out_channel, demod_value, output ready);
endinterface

[hw/rtl/ameb_front.sv]
`timescale 1ns / 1ps

module ameb_front #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  ameb_in_if.sink                      iq,
  output logic                         push,
  output logic [ameb_pkg::CH_BITS-1:0] push_ch,
  output logic [SAMPLE_BITS:0]         push_env,
  input  ameb_pkg::fifo_stat_t         stat
);
  import ameb_pkg::*;

  localparam int ENV_BITS = SAMPLE_BITS + 1;
  localparam int SQ_BITS  = 2 * SAMPLE_BITS - 1;
  localparam int PWR_BITS = 2 * SAMPLE_BITS;
  localparam int XW       = 2 * ENV_BITS;
  localparam int RW       = ENV_BITS + 2;
  localparam int CW       = $clog2(ENV_BITS);

  front_state_t state, state_next;

  logic [CH_BITS-1:0]        ch;
  logic signed [SAMPLE_BITS-1:0] si, sq;
  logic [SQ_BITS-1:0]        sqi, sqq;
  logic [XW-1:0]             xr;
  logic [RW-1:0]             rem;
  logic [ENV_BITS-1:0]       root;
  logic [CW-1:0]             cnt;

  logic signed [PWR_BITS-1:0] prod_i, prod_q;
  logic [PWR_BITS-1:0]        power;
  logic [RW-1:0]              rem_sh, trial;
  logic                       take;

  assign prod_i = si * si;
  assign prod_q = sq * sq;
  assign power  = {1'b0, sqi} + {1'b0, sqq};

  // One result bit of the integer square root per cycle.
  assign rem_sh = {rem[RW-3:0], xr[XW-1:XW-2]};
  assign trial  = {root, 2'b01};
  assign take   = rem_sh >= trial;

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (iq.valid) state_next = F_SQR;
      F_SQR:  state_next = F_SUM;
      F_SUM:  state_next = F_ROOT;
      F_ROOT: if (cnt == '0) state_next = F_PUSH;
      F_PUSH: if (!stat.full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    iq.ready = (state == F_IDLE);
    push     = (state == F_PUSH) && !stat.full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      F_IDLE: begin
        if (iq.valid) begin
          ch <= iq.channel;
          si <= iq.sample_i;
          sq <= iq.sample_q;
        end
      end
      F_SQR: begin
        sqi <= prod_i[SQ_BITS-1:0];
        sqq <= prod_q[SQ_BITS-1:0];
      end
      F_SUM: begin
        xr   <= {2'b00, power};
        rem  <= '0;
        root <= '0;
        cnt  <= CW'(ENV_BITS - 1);
      end
      F_ROOT: begin
        xr   <= {xr[XW-3:0], 2'b00};
        rem  <= take ? (rem_sh - trial) : rem_sh;
        root <= {root[ENV_BITS-2:0], take};
        cnt  <= cnt - 1'b1;
      end
      F_PUSH: begin
      end
      default: begin
      end
    endcase
  end

  assign push_ch  = ch;
  assign push_env = root;

endmodule

[hw/rtl/ameb_fifo.sv]
`timescale 1ns / 1ps

module ameb_fifo #(
  parameter int WIDTH = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [WIDTH-1:0]     push_data,
  input  logic                 pop,
  output logic [WIDTH-1:0]     pop_data,
  output ameb_pkg::fifo_stat_t stat
);
  import ameb_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  assign pop_data   = slots[rd_ptr];
  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);

endmodule

[hw/rtl/ameb_back.sv]
`timescale 1ns / 1ps

module ameb_back #(
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [ameb_pkg::ALPHA_BITS-1:0] alpha,
  output logic                            pop,
  input  logic [ameb_pkg::CH_BITS-1:0]    pop_ch,
  input  logic [SAMPLE_BITS:0]            pop_env,
  input  ameb_pkg::fifo_stat_t            stat,
  ameb_out_if.source                      demod
);
  import ameb_pkg::*;

  localparam int ENV_BITS = SAMPLE_BITS + 1;
  localparam int OUT_BITS = SAMPLE_BITS + 3;
  localparam int CH_SPAN  = 1 << CH_BITS;
  localparam int ST_DEPTH = (CHANNELS < CH_SPAN) ? CHANNELS : CH_SPAN;
  localparam int IDX_W    = (ST_DEPTH > 1) ? $clog2(ST_DEPTH) : 1;
  localparam int PW       = OUT_BITS + ALPHA_BITS + 1;
  localparam int SW       = PW + 1;
  localparam int FW       = SW - ALPHA_BITS;
  localparam int YW       = OUT_BITS + 3;

  back_state_t state, state_next;

  logic [ENV_BITS-1:0]        st_env [ST_DEPTH];
  logic signed [OUT_BITS-1:0] st_out [ST_DEPTH];

  logic [CH_BITS-1:0]         cur_ch;
  logic [ENV_BITS-1:0]        cur_env, prev_env;
  logic signed [OUT_BITS-1:0] prev_out;
  logic                       ch_ok;
  logic signed [PW-1:0]       prod;

  logic                       out_valid;
  logic [CH_BITS-1:0]         out_ch;
  logic signed [OUT_BITS-1:0] out_val;

  logic [IDX_W-1:0]           ridx, widx;
  logic                       pop_ok, out_free, load;
  logic [SW-1:0]              fb_sum;
  logic [FW-1:0]              fb;
  logic [YW-1:0]              y;
  logic signed [OUT_BITS-1:0] y_sat;

  assign ridx   = pop_ch[IDX_W-1:0];
  assign widx   = cur_ch[IDX_W-1:0];
  assign pop_ok = 32'(pop_ch) < CHANNELS;

  // Feedback term rounded to nearest, ties toward plus infinity.
  assign fb_sum = {prod[PW-1], prod} + SW'(1 << (ALPHA_BITS - 1));
  assign fb     = fb_sum[SW-1:ALPHA_BITS];
  assign y      = {{(YW-ENV_BITS){1'b0}}, cur_env} - {{(YW-ENV_BITS){1'b0}}, prev_env}
                  + {{(YW-FW){fb[FW-1]}}, fb};

  always_comb begin
    if (!y[YW-1] && (|y[YW-2:OUT_BITS-1])) begin
      y_sat = {1'b0, {(OUT_BITS-1){1'b1}}};
    end else if (y[YW-1] && !(&y[YW-2:OUT_BITS-1])) begin
      y_sat = {1'b1, {(OUT_BITS-1){1'b0}}};
    end else begin
      y_sat = y[OUT_BITS-1:0];
    end
  end

  assign out_free = !out_valid || demod.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (!stat.empty) state_next = B_MUL;
      B_MUL:   state_next = B_SUM;
      B_SUM:   if (out_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop  = (state == B_IDLE) && !stat.empty;
    load = (state == B_SUM) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      for (int k = 0; k < ST_DEPTH; k++) begin
        st_env[k] <= '0;
        st_out[k] <= '0;
      end
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (demod.ready) begin
        out_valid <= 1'b0;
      end
      if (load && ch_ok) begin
        st_env[widx] <= cur_env;
        st_out[widx] <= y_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_ch   <= pop_ch;
      cur_env  <= pop_env;
      ch_ok    <= pop_ok;
      prev_env <= pop_ok ? st_env[ridx] : '0;
      prev_out <= pop_ok ? st_out[ridx] : '0;
    end
    if (state == B_MUL) begin
      prod <= $signed({1'b0, alpha}) * prev_out;
    end
    if (load) begin
      out_ch  <= cur_ch;
      out_val <= y_sat;
    end
  end

  assign demod.valid       = out_valid;
  assign demod.out_channel = out_ch;
  assign demod.demod_value = out_val;

endmodule

[hw/rtl/am_envelope_dc_block.sv]
`timescale 1ns / 1ps

// Channel   Role          Beat contents
// --------  ------------  ------------------------------------------
// iq        sink          channel, sample_i, sample_q
// demod     source        out_channel, demod_value
// APB       config slave  dc_alpha at byte address 0
//
// Each sample passes through the front end's square, sum, square root and push states,
// with the square root unit resolving one envelope bit per cycle.
// The DC blocker pops, multiplies and sums each beat, overlapping the next square root.
// Reset is synchronous; it clears the per-channel state and sets dc_alpha to 32604.
// A stalled output holds the DC blocker; two queued envelopes let the front keep going.

module am_envelope_dc_block #(
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  ameb_in_if.sink                             iq,
  ameb_out_if.source                          demod,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ameb_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  logic [ameb_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [ameb_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                                pready
);
  import ameb_pkg::*;

  localparam int ENV_BITS = SAMPLE_BITS + 1;
  localparam int QW       = CH_BITS + ENV_BITS;

  logic [ALPHA_BITS-1:0] dc_alpha;
  logic                  reg_hit;

  logic                  push, pop;
  logic [CH_BITS-1:0]    push_ch, pop_ch;
  logic [ENV_BITS-1:0]   push_env, pop_env;
  logic [QW-1:0]         pop_data;
  fifo_stat_t            stat;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_ADDR_BITS-1:2] == REG_DC_ALPHA);
  assign prdata  = reg_hit ? {{(APB_DATA_BITS-ALPHA_BITS){1'b0}}, dc_alpha} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dc_alpha <= ALPHA_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      dc_alpha <= pwdata[ALPHA_BITS-1:0];
    end
  end

  ameb_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .iq       (iq),
    .push     (push),
    .push_ch  (push_ch),
    .push_env (push_env),
    .stat     (stat)
  );

  ameb_fifo #(
    .WIDTH (QW)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_ch, push_env}),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (stat)
  );

  assign pop_ch  = pop_data[QW-1:ENV_BITS];
  assign pop_env = pop_data[ENV_BITS-1:0];

  ameb_back #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .alpha   (dc_alpha),
    .pop     (pop),
    .pop_ch  (pop_ch),
    .pop_env (pop_env),
    .stat    (stat),
    .demod   (demod)
  );

`ifndef ASSERT_OFF
  a_push_room: assert property (@(posedge clk) disable iff (rst) push |-> !stat.full)
    else $error("envelope pushed into a full queue");

  a_pop_data: assert property (@(posedge clk) disable iff (rst) pop |-> !stat.empty)
    else $error("DC blocker popped an empty queue");

  a_alpha_reset: assert property (@(posedge clk) $fell(rst) |-> dc_alpha == ALPHA_RESET)
    else $error("dc_alpha not at its reset value after reset");

  a_out_quiet: assert property (@(posedge clk) $past(rst) |-> !demod.valid)
    else $error("result beat offered right after reset");
`endif

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

typedef struct {
  logic [2:0]         channel;
  logic signed [18:0] value;
} demod_beat_t;

// Tracks the per-channel DC blocker state and the demodulated beats still owed by the block.
class demod_scoreboard;
  logic [14:0]        alpha;
  logic [16:0]        env_hist[8];
  logic signed [18:0] out_hist[8];
  demod_beat_t        awaited[$];
  int                 errors;

  function new();
    alpha = ameb_pkg::ALPHA_RESET;
    foreach (env_hist[k]) begin
      env_hist[k] = '0;
      out_hist[k] = '0;
    end
    errors = 0;
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  function void note_sample(logic [2:0] ch, logic signed [15:0] si, logic signed [15:0] sq);
    longint power;
    longint env;
    longint trial;
    longint fb;
    longint y;
    demod_beat_t beat;
    power = longint'(si) * si + longint'(sq) * sq;
    // Integer square root rounded down, one bit at a time.
    env = 0;
    for (int b = 16; b >= 0; b--) begin
      trial = env | (longint'(1) << b);
      if (trial * trial <= power) env = trial;
    end
    // Feedback term rounds to nearest with ties toward plus infinity.
    fb = (longint'(alpha) * out_hist[ch] + 16384) >>> 15;
    y = env - longint'(env_hist[ch]) + fb;
    if (y > 262143) y = 262143;
    if (y < -262144) y = -262144;
    env_hist[ch] = 17'(env);
    out_hist[ch] = 19'(y);
    beat.channel = ch;
    beat.value   = 19'(y);
    awaited.push_back(beat);
  endfunction

  function void check_result(logic [2:0] ch, logic signed [18:0] val);
    demod_beat_t want;
    if (awaited.size() == 0) begin
      $display("%0t: unexpected demod beat, expected none, actual channel %0d value %0d",
               $time, ch, val);
      errors++;
      return;
    end
    want = awaited.pop_front();
    if (ch !== want.channel) begin
      $display("%0t: out_channel mismatch, expected %0d, actual %0d", $time, want.channel, ch);
      errors++;
    end
    if (val !== want.value) begin
      $display("%0t: demod_value mismatch, expected %0d, actual %0d", $time, want.value, val);
      errors++;
    end
  endfunction
endclass

module tb;
  import ameb_pkg::*;

  localparam int          RANDOM_PER_PHASE = 135;
  localparam int          CYCLE_LIMIT      = 500000;
  localparam logic [2:0]  ADDR_DC_ALPHA    = {REG_DC_ALPHA, 2'b00};
  // Byte address of the first register index past the end of the map.
  localparam logic [2:0]  ADDR_UNMAPPED    = 3'd4;

  logic                     clk;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  int send_idle_pct;
  int recv_idle_pct;
  int cycles;

  logic [2:0]         last_ch;
  logic signed [15:0] rand_i;
  logic signed [15:0] rand_q;

  ameb_in_if  #(.SAMPLE_BITS(16)) iq_if ();
  ameb_out_if #(.SAMPLE_BITS(16)) demod_if ();

  demod_scoreboard sb = new();

  am_envelope_dc_block #(
    .CHANNELS    (8),
    .SAMPLE_BITS (16)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .iq      (iq_if),
    .demod   (demod_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    iq_if.valid = 1'b0;
    iq_if.channel = '0;
    iq_if.sample_i = '0;
    iq_if.sample_q = '0;
    demod_if.ready = 1'b0;
    send_idle_pct = 8;
    recv_idle_pct = 72;
    cycles = 0;
  end

  always #10 clk = ~clk;

  always @(negedge clk) begin
    demod_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && demod_if.valid && demod_if.ready) begin
      sb.check_result(demod_if.out_channel, demod_if.demod_value);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_sample(input logic [2:0] ch, input logic signed [15:0] si,
                             input logic signed [15:0] sq);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      iq_if.valid <= 1'b0;
      @(negedge clk);
    end
    iq_if.valid    <= 1'b1;
    iq_if.channel  <= ch;
    iq_if.sample_i <= si;
    iq_if.sample_q <= sq;
    do @(posedge clk); while (!iq_if.ready);
    sb.note_sample(ch, si, sq);
  endtask

  task automatic drain();
    @(negedge clk);
    iq_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_DC_ALPHA) sb.alpha = data[14:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_component();
    case ($urandom_range(0, 3))
      0, 1: return 16'($urandom);
      2: return 16'(int'($urandom_range(0, 64)) - 32);
      default: begin
        case ($urandom_range(0, 4))
          0: return -16'sd32768;
          1: return -16'sd1;
          2: return 16'sd0;
          3: return 16'sd1;
          default: return 16'sd32767;
        endcase
      end
    endcase
  endfunction

  task automatic random_phase(input int count);
    for (int n = 0; n < count; n++) begin
      // Bursts on one channel stress back-to-back state updates.
      if ($urandom_range(0, 1) == 0) last_ch = 3'($urandom_range(0, 7));
      rand_i = pick_component();
      rand_q = pick_component();
      send_sample(last_ch, rand_i, rand_q);
    end
    drain();
  endtask

  initial begin
    last_ch = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset coefficient. With eight channels every channel number
    // is in range, so the out-of-range case cannot be reached.
    send_sample(3'd0, 16'sd0, 16'sd0);
    send_sample(3'd0, -16'sd32768, -16'sd32768);
    send_sample(3'd0, 16'sd0, 16'sd0);
    send_sample(3'd0, 16'sd32767, 16'sd32767);
    send_sample(3'd0, 16'sd32767, -16'sd32768);
    send_sample(3'd1, -16'sd32768, 16'sd0);
    send_sample(3'd1, 16'sd0, -16'sd32768);
    send_sample(3'd1, 16'sd0, 16'sd32767);
    send_sample(3'd2, 16'sd1, 16'sd0);
    send_sample(3'd2, -16'sd1, -16'sd1);
    send_sample(3'd2, 16'sd3, 16'sd4);
    send_sample(3'd3, -16'sd32768, -16'sd32768);
    send_sample(3'd3, -16'sd32768, -16'sd32768);
    send_sample(3'd4, 16'sd32767, 16'sd0);
    send_sample(3'd5, 16'sd0, 16'sd1);
    send_sample(3'd6, 16'sd100, -16'sd100);
    send_sample(3'd7, -16'sd32768, 16'sd32767);
    send_sample(3'd7, 16'sd0, 16'sd0);
    send_sample(3'd7, 16'sd0, 16'sd0);
    send_sample(3'd5, -16'sd32768, -16'sd32768);
    send_sample(3'd6, 16'sd0, 16'sd0);
    drain();

    apb_write(ADDR_DC_ALPHA, 32'd32767);
    random_phase(RANDOM_PER_PHASE);

    send_idle_pct = 72;
    recv_idle_pct = 8;
    apb_write(ADDR_DC_ALPHA, 32'd0);
    // A write past the register map must leave the coefficient alone.
    apb_write(ADDR_UNMAPPED, 32'd12345);
    random_phase(RANDOM_PER_PHASE);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    apb_write(ADDR_DC_ALPHA, 32'($urandom_range(1, 32766)));
    random_phase(RANDOM_PER_PHASE);

    // Catch any stray beat the block might still emit.
    repeat (60) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
